// ----- rtl/core/random_free_cell_select_unit_assert.svh -----
// Assertion macros used by the checker file of the free cell select unit.
`ifndef RANDOM_FREE_CELL_SELECT_UNIT_ASSERT_SVH
`define RANDOM_FREE_CELL_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfcs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfcs assertion failed");

`endif

// ----- rtl/core/rfcs_pkg.sv -----
// Shared types and constants of the free cell select unit.
package rfcs_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;

    localparam int COORD_W = 5;
    localparam int WORD_W  = 31;
    localparam int CNT_W   = 11;
    localparam int DIM_W   = 7;
    localparam int GRID_W  = 6;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int MODE_W  = 2;
    localparam int REM_W   = CNT_W + 1;
    localparam int DIVC_W  = 5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam int COUNT_MAX = 2047;

    localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = 6'd15;
    localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = 6'd15;
    localparam logic [CNT_W-1:0]  RESERVE_RST     = 11'd10;

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_RESERVE     = 2'd2,
        REG_UNUSED      = 2'd3
    } rfcs_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_MARK_PICK = 2'd0,
        MODE_PICK      = 2'd1,
        MODE_NEW_GAME  = 2'd2,
        MODE_NONE      = 2'd3
    } rfcs_mode_t;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic load_count;
        logic mark_rd;
        logic mark_wr;
        logic div_init;
        logic div_step;
        logic scan_init;
        logic scan_step;
    } rfcs_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic pick_ok;
        logic div_last;
        logic hit;
        logic scan_end;
    } rfcs_stat_t;

endpackage

// ----- rtl/core/rfcs_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module rfcs_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/rfcs_ctrl.sv -----
// Controller state machine of the free cell select unit.
module rfcs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [rfcs_pkg::MODE_W-1:0]   in_mode,
    output logic                          s_tready,
    input  rfcs_pkg::rfcs_stat_t          stat,
    output rfcs_pkg::rfcs_cmd_t           cmd,
    input  logic                          out_free,
    output logic                          out_load
);
    import rfcs_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK_RD,
        S_MARK_WR,
        S_PICK,
        S_DIV,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   newgame_reg, newgame_next;

    always_comb begin
        state_next   = state_reg;
        newgame_next = newgame_reg;
        cmd          = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    cmd.load_count = newgame_reg;
                    newgame_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    unique case (rfcs_mode_t'(in_mode))
                        MODE_MARK_PICK: state_next = S_MARK_RD;
                        MODE_PICK:      state_next = S_PICK;
                        MODE_NEW_GAME: begin
                            newgame_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        MODE_NONE:      state_next = S_IDLE;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_MARK_RD: begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_WR;
            end
            S_MARK_WR: begin
                cmd.mark_wr = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK: begin
                if (stat.pick_ok) begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.hit || stat.scan_end) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            newgame_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            newgame_reg <= newgame_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- rtl/core/rfcs_dpath.sv -----
// Datapath: configuration, occupancy map, free count, divider and scan.
module rfcs_dpath #(
    parameter int MAX_WIDTH  = rfcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rfcs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rfcs_pkg::IDX_W-1:0]       cfg_index,
    input  logic [rfcs_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [rfcs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  rfcs_pkg::rfcs_cmd_t              cmd,
    output rfcs_pkg::rfcs_stat_t             stat,
    output logic [rfcs_pkg::COORD_W-1:0]     res_x,
    output logic [rfcs_pkg::COORD_W-1:0]     res_y,
    output logic                             res_placed
);
    import rfcs_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    logic [GRID_W-1:0]  gw_reg, gh_reg;
    logic [CNT_W-1:0]   thr_reg;
    logic [CNT_W-1:0]   free_cnt_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               issue_reg, tv_reg;
    logic               res_placed_reg;

    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIVC_W-1:0]  div_cnt_reg;
    logic [DIM_W-1:0]   sx_reg, sy_reg, tx_reg, ty_reg;
    logic [CNT_W-1:0]   seen_reg;
    logic [COORD_W-1:0] res_x_reg, res_y_reg;

    logic [DIM_W-1:0]   eff_w, eff_h, cx_ext, cy_ext;
    logic [2*DIM_W-1:0] area;
    logic [CNT_W-1:0]   count_init;
    logic               in_grid, cell_free, hit, x_last, y_last;
    logic [REM_W-1:0]   trial;
    logic               trial_ge;

    logic               ram_we, ram_wd, ram_rd;
    logic [AW-1:0]      ram_wa, ram_ra;

    // Effective grid size is clipped to the storage limits.
    assign eff_w = ({1'b0, gw_reg} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : {1'b0, gw_reg};
    assign eff_h = ({1'b0, gh_reg} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : {1'b0, gh_reg};
    assign area  = eff_w * eff_h;
    assign count_init = (area > (2*DIM_W)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : area[CNT_W-1:0];

    assign cx_ext  = {2'b00, cx_reg};
    assign cy_ext  = {2'b00, cy_reg};
    assign in_grid = (cx_ext < eff_w) && (cy_ext < eff_h);

    assign cell_free = !ram_rd;
    assign hit       = tv_reg && cell_free && (seen_reg == rem_reg[CNT_W-1:0]);
    assign x_last    = (sx_reg == eff_w - DIM_W'(1));
    assign y_last    = (sy_reg == eff_h - DIM_W'(1));

    // One restoring division step per cycle, remainder only.
    assign trial    = {rem_reg[CNT_W-1:0], word_reg[WORD_W-1]};
    assign trial_ge = (trial >= {1'b0, free_cnt_reg});

    assign ram_we = cmd.clr_step || (cmd.mark_wr && in_grid) || (cmd.scan_step && hit);
    assign ram_wd = !cmd.clr_step;
    always_comb begin
        priority if (cmd.clr_step) begin
            ram_wa = clr_addr_reg;
        end else if (cmd.mark_wr) begin
            ram_wa = {cy_ext[YW-1:0], cx_ext[XW-1:0]};
        end else begin
            ram_wa = {ty_reg[YW-1:0], tx_reg[XW-1:0]};
        end
    end
    assign ram_ra = cmd.mark_rd ? {cy_ext[YW-1:0], cx_ext[XW-1:0]}
                                : {sy_reg[YW-1:0], sx_reg[XW-1:0]};

    rfcs_ram #(
        .DATA_W (1),
        .DEPTH  (DEPTH)
    ) u_map (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // Control state: configuration, free count, sweep and scan flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg         <= GRID_WIDTH_RST;
            gh_reg         <= GRID_HEIGHT_RST;
            thr_reg        <= RESERVE_RST;
            free_cnt_reg   <= '0;
            clr_addr_reg   <= '0;
            issue_reg      <= 1'b0;
            tv_reg         <= 1'b0;
            res_placed_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (rfcs_reg_t'(cfg_index))
                    REG_GRID_WIDTH:  gw_reg  <= cfg_wdata[GRID_W-1:0];
                    REG_GRID_HEIGHT: gh_reg  <= cfg_wdata[GRID_W-1:0];
                    REG_RESERVE:     thr_reg <= cfg_wdata[CNT_W-1:0];
                    REG_UNUSED:      ;
                    default:         ;
                endcase
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load_count) begin
                free_cnt_reg <= count_init;
            end else if (cmd.mark_wr && in_grid && cell_free && free_cnt_reg != '0) begin
                free_cnt_reg <= free_cnt_reg - CNT_W'(1);
            end else if (cmd.scan_step && hit) begin
                free_cnt_reg <= free_cnt_reg - CNT_W'(1);
            end
            if (cmd.scan_init) begin
                issue_reg <= (eff_w != '0) && (eff_h != '0);
                tv_reg    <= 1'b0;
            end else if (cmd.scan_step) begin
                tv_reg <= issue_reg;
                if (issue_reg && x_last && y_last) begin
                    issue_reg <= 1'b0;
                end
            end
            if (cmd.load_item) begin
                res_placed_reg <= 1'b0;
            end else if (cmd.scan_step && hit) begin
                res_placed_reg <= 1'b1;
            end
        end
    end

    // Payload: item fields, divider and scan position.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cx_reg    <= s_tdata[COORD_W-1:0];
            cy_reg    <= s_tdata[2*COORD_W-1:COORD_W];
            word_reg  <= s_tdata[2*COORD_W+WORD_W-1:2*COORD_W];
            res_x_reg <= '0;
            res_y_reg <= '0;
        end else if (cmd.scan_step && hit) begin
            res_x_reg <= tx_reg[COORD_W-1:0];
            res_y_reg <= ty_reg[COORD_W-1:0];
        end
        if (cmd.div_init) begin
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= trial_ge ? (trial - {1'b0, free_cnt_reg}) : trial;
            word_reg    <= {word_reg[WORD_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
        end
        if (cmd.scan_init) begin
            sx_reg   <= '0;
            sy_reg   <= '0;
            seen_reg <= '0;
        end else if (cmd.scan_step) begin
            if (issue_reg) begin
                tx_reg <= sx_reg;
                ty_reg <= sy_reg;
                if (x_last) begin
                    sx_reg <= '0;
                    sy_reg <= sy_reg + DIM_W'(1);
                end else begin
                    sx_reg <= sx_reg + DIM_W'(1);
                end
            end
            if (tv_reg && cell_free && !hit) begin
                seen_reg <= seen_reg + CNT_W'(1);
            end
        end
    end

    assign stat.clr_last = &clr_addr_reg;
    assign stat.pick_ok  = (free_cnt_reg > thr_reg) && (free_cnt_reg != '0);
    assign stat.div_last = (div_cnt_reg == DIVC_W'(WORD_W - 1));
    assign stat.hit      = hit;
    assign stat.scan_end = !issue_reg && !tv_reg;

    assign res_x      = res_x_reg;
    assign res_y      = res_y_reg;
    assign res_placed = res_placed_reg;

endmodule

// ----- rtl/core/random_free_cell_select_unit.sv -----
// Top level of the random free cell select unit.
//
// The block keeps an occupancy map of a grid of up to MAX_WIDTH by MAX_HEIGHT
// cells and a count of free cells. Input beats arrive on the s_ channel: the
// mode travels in s_tuser, the cell to mark and the random word in s_tdata.
// A new-game beat clears the map and loads the count with width times height.
// A mark beat records the given cell as occupied and then picks; a pick-only
// beat just picks. Each mark or pick beat yields exactly one result beat on the
// m_ channel: the chosen cell in m_tdata and the placed flag in m_tuser, or a
// pass at 0,0 when the free count does not exceed the reserve threshold or the scan finds no free cell.
// Configuration is written through the cfg_ port; the user must do so only while the
// block is idle, which the block itself does not enforce. One item is processed at a time.
// A mark beat reads and then writes the map; then the reserve is checked and, if it allows
// a pick, the divider forms the remainder (one restoring step per bit of the random word)
// and the row-major scan walks the grid cells through the registered map read until a hit
// or the end. The result then waits until the output register is free and is loaded into
// it. A new game clears the map one word per cycle, 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) words, 1024 by default.
// After reset the same clearing pass runs and s_tready stays low for it.
// A finished result waits in the output register while the receiver stalls;
// the block holds off the next result until that beat is taken.
module random_free_cell_select_unit #(
    parameter int MAX_WIDTH  = rfcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rfcs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input beats.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cell_x [4:0], cell_y [9:5], random_word [40:10], zero fill above.
    input  logic [rfcs_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode [1:0].
    input  logic [rfcs_pkg::MODE_W-1:0]     s_tuser,
    // Result beats.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pick_x [4:0], pick_y [9:5], zero fill above.
    output logic [rfcs_pkg::M_TDATA_W-1:0]  m_tdata,
    // placed [0].
    output logic                            m_tuser,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [rfcs_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rfcs_pkg::CFG_W-1:0]      cfg_wdata
);
    import rfcs_pkg::*;

    rfcs_cmd_t          cmd;
    rfcs_stat_t         stat;
    logic               out_free, out_load;
    logic [COORD_W-1:0] res_x, res_y;
    logic               res_placed;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // The output register is free when empty or when its beat leaves now.
    assign out_free = !m_tvalid_reg || m_tready;

    rfcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_mode  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .out_free (out_free),
        .out_load (out_load)
    );

    rfcs_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tdata    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_placed (res_placed)
    );

    // Output register: valid is control state, the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - 2*COORD_W){1'b0}}, res_y, res_x};
            m_tuser_reg <= res_placed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/core/rfcs_checker.sv -----
// Port-level checker of the free cell select unit and its bind.
`include "random_free_cell_select_unit_assert.svh"

module rfcs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rfcs_pkg::MODE_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rfcs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);
    import rfcs_pkg::*;

    logic s_beat_busy;

    // Every accepted beat but the unused mode keeps the block busy afterwards.
    assign s_beat_busy = s_tvalid && s_tready && (s_tuser != MODE_NONE);

    `RFCS_ASSERT_NXT(a_stall_keeps_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `RFCS_ASSERT_NXT(a_stall_keeps_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `RFCS_ASSERT_IMP(a_pass_at_origin, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `RFCS_ASSERT_NXT(a_one_item_at_a_time, aclk, aresetn, s_beat_busy, !s_tready)

endmodule

bind random_free_cell_select_unit rfcs_checker u_rfcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/random_free_cell_select_unit_test.sv -----
// Self-checking testbench for the random free cell select unit.
`timescale 1ns / 1ps

module random_free_cell_select_unit_test;
    import rfcs_pkg::*;

    // Scan geometry of the occupancy map as the block is built by default.
    localparam int GRID_COLS = MAX_WIDTH_DEF;
    localparam int GRID_ROWS = MAX_HEIGHT_DEF;

    // A full 32 by 32 scan plus the remainder and a new game both finish within
    // this many idle cycles, so any beat that produces no result is done before
    // the registers change.
    localparam int SETTLE_CYCLES = 1200;
    localparam int RANDOM_ITEMS  = 480;
    localparam int RUN_LIMIT     = 4_000_000;

    // One expected result beat, in the same order as the fields on m_.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               placed;
    } pick_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // Shadow copy of the block: registers, occupancy map and free count.
    logic [GRID_W-1:0] width_reg   = GRID_WIDTH_RST;
    logic [GRID_W-1:0] height_reg  = GRID_HEIGHT_RST;
    logic [CNT_W-1:0]  reserve_reg = RESERVE_RST;
    bit                occupied [GRID_ROWS][GRID_COLS];
    logic [CNT_W-1:0]  free_cells  = '0;

    // Results that the shadow model has produced but the block has not yet sent.
    pick_t pending_picks[$];

    // When set, both the sender and the receiver run without gaps.
    bit steady_flow = 1'b0;

    int unsigned error_count     = 0;
    int unsigned results_checked = 0;
    int unsigned beats_sent      = 0;
    int unsigned random_items    = 0;
    int unsigned games_started   = 0;
    int unsigned placements      = 0;
    int unsigned passes          = 0;
    int unsigned phases_run      = 0;
    int unsigned cycle_count     = 0;

    random_free_cell_select_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Sizes above the map limit collapse onto the limit; zero is an empty grid.
    function automatic int unsigned span(logic [GRID_W-1:0] size, int unsigned limit);
        return (32'(size) > limit) ? limit : 32'(size);
    endfunction

    // Updates the shadow state for one accepted beat and queues the result
    // that the block must send for it, if any.
    function automatic void predict_pick(rfcs_mode_t mode, logic [COORD_W-1:0] cx,
                                         logic [COORD_W-1:0] cy, logic [WORD_W-1:0] word);
        int unsigned cols;
        int unsigned rows;
        int unsigned target;
        int unsigned seen;
        int unsigned area;
        bit          found;
        pick_t       res;

        cols = span(width_reg, GRID_COLS);
        rows = span(height_reg, GRID_ROWS);
        case (mode)
            MODE_NEW_GAME: begin
                foreach (occupied[r, c]) occupied[r][c] = 1'b0;
                area = cols * rows;
                free_cells = (area > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(area);
                games_started++;
            end
            MODE_NONE: begin
                // The spare mode leaves everything alone and sends nothing.
            end
            default: begin
                // A mark only counts down when it lands on a free cell inside the
                // grid; with a zero count the cell is still recorded as taken.
                if (mode == MODE_MARK_PICK && 32'(cx) < cols && 32'(cy) < rows
                        && !occupied[cy][cx]) begin
                    occupied[cy][cx] = 1'b1;
                    if (free_cells != 0) free_cells--;
                end
                res = '0;
                found = 1'b0;
                if (free_cells > reserve_reg) begin
                    target = 32'(word) % 32'(free_cells);
                    seen = 0;
                    // Row-major walk for the selected free cell. When the count
                    // claims more free cells than the grid holds, the walk can run
                    // out and the result stays a pass.
                    for (int r = 0; r < rows; r++) begin
                        for (int c = 0; c < cols; c++) begin
                            if (!found && !occupied[r][c]) begin
                                if (seen == target) begin
                                    occupied[r][c] = 1'b1;
                                    free_cells--;
                                    res.x = COORD_W'(c);
                                    res.y = COORD_W'(r);
                                    res.placed = 1'b1;
                                    found = 1'b1;
                                end
                                seen++;
                            end
                        end
                    end
                end
                if (found) placements++;
                else passes++;
                pending_picks.push_back(res);
            end
        endcase
    endfunction

    // Presents one beat after a random gap, or none in steady flow, and waits
    // until the block takes it. tvalid is left high so that a following beat
    // with no gap goes out back to back.
    task automatic send_item(rfcs_mode_t mode, logic [COORD_W-1:0] cx,
                             logic [COORD_W-1:0] cy, logic [WORD_W-1:0] word);
        int unsigned gap;

        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - WORD_W - 2 * COORD_W){1'b0}}, word, cy, cx};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_pick(mode, cx, cy, word);
        beats_sent++;
    endtask

    task automatic idle_inputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Stops sending and waits until every queued result has been checked.
    task automatic drain_results();
        idle_inputs();
        while (pending_picks.size() != 0) @(posedge aclk);
    endtask

    // Brings the block to rest: beats that produce no result may still be
    // working, so a fixed pause follows the last result.
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(rfcs_reg_t idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  width_reg   = value[GRID_W-1:0];
            REG_GRID_HEIGHT: height_reg  = value[GRID_W-1:0];
            REG_RESERVE:     reserve_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [GRID_W-1:0] cols, logic [GRID_W-1:0] rows,
                            logic [CNT_W-1:0] reserve);
        settle_block();
        write_reg(REG_GRID_WIDTH, CFG_W'(cols));
        write_reg(REG_GRID_HEIGHT, CFG_W'(rows));
        write_reg(REG_RESERVE, reserve);
    endtask

    // Straight after reset the free count is zero: picks pass, and a mark
    // still takes its cell without counting down. The spare mode sends nothing.
    task automatic test_empty_count();
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd0);
        send_item(MODE_MARK_PICK, 5'd3, 5'd4, 31'd17);
        send_item(MODE_NONE, 5'd31, 5'd31, 31'h7FFF_FFFF);
    endtask

    // A game on the default 15 by 15 grid: random word extremes, a corner
    // mark, a repeated mark and marks just outside and far outside the grid.
    task automatic test_first_game();
        send_item(MODE_NEW_GAME, 5'd0, 5'd0, 31'd0);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd0);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'h7FFF_FFFF);
        send_item(MODE_MARK_PICK, 5'd14, 5'd14, 31'd0);
        send_item(MODE_MARK_PICK, 5'd14, 5'd14, 31'd224);
        // The sender holds back here until the block has answered everything.
        drain_results();
        send_item(MODE_MARK_PICK, 5'd31, 5'd31, 31'h7FFF_FFFF);
        send_item(MODE_MARK_PICK, 5'd15, 5'd0, 31'h5555_5555);
        send_item(MODE_NONE, 5'd7, 5'd9, 31'h2AAA_AAAA);
    endtask

    // Width beyond the map limit is clamped to 32; a zero width is an empty
    // grid whose count is zero, so marks and picks there change nothing.
    task automatic test_grid_limits();
        set_grid(6'd63, 6'd32, 11'd0);
        send_item(MODE_NEW_GAME, 5'd0, 5'd0, 31'd0);
        send_item(MODE_MARK_PICK, 5'd31, 5'd31, 31'h7FFF_FFFF);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd1023);
        set_grid(6'd0, 6'd1, 11'd0);
        send_item(MODE_NEW_GAME, 5'd0, 5'd0, 31'd0);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd5);
        send_item(MODE_MARK_PICK, 5'd0, 5'd0, 31'd0);
    endtask

    // The grid shrinks after a new game, so the count exceeds the cells that
    // the scan can reach: a selection past the last free cell is a pass.
    task automatic test_shrunk_grid();
        set_grid(6'd4, 6'd4, 11'd0);
        send_item(MODE_NEW_GAME, 5'd0, 5'd0, 31'd0);
        set_grid(6'd2, 6'd2, 11'd0);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd15);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd0);
    endtask

    // The reserve at its top value blocks every pick; at one it allows picks
    // down to a count of two and passes once the count equals it.
    task automatic test_reserve_edge();
        set_grid(6'd3, 6'd1, 11'd2047);
        send_item(MODE_NEW_GAME, 5'd0, 5'd0, 31'd0);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd2);
        settle_block();
        write_reg(REG_RESERVE, 11'd1);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd2);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'h7FFF_FFFF);
        send_item(MODE_PICK, 5'd0, 5'd0, 31'd0);
    endtask

    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return WORD_W'($urandom_range(0, 2047));
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [GRID_W-1:0] draw_size();
        case ($urandom_range(0, 19))
            0:       return GRID_W'($urandom_range(33, 63));
            1:       return 6'd0;
            2, 3:    return GRID_W'($urandom_range(13, 32));
            default: return GRID_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Phases with a fresh configuration, mostly starting with a new game and
    // followed by marks and picks inside the grid. Noise beats (spare mode,
    // marks anywhere, a restart in mid game) and occasional full drains are
    // mixed in. Some phases skip the new game and keep the old map.
    task automatic test_random_games();
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      phase_len;
        int unsigned      roll;
        logic [CNT_W-1:0] reserve;

        while (random_items < RANDOM_ITEMS) begin
            settle_block();
            phases_run++;
            steady_flow = ($urandom_range(0, 3) == 0);
            write_reg(REG_GRID_WIDTH, CFG_W'(draw_size()));
            write_reg(REG_GRID_HEIGHT, CFG_W'(draw_size()));
            cols = span(width_reg, GRID_COLS);
            rows = span(height_reg, GRID_ROWS);
            case ($urandom_range(0, 9))
                0:       reserve = 11'd1024;
                1:       reserve = CNT_W'($urandom_range(0, 2047));
                2, 3:    reserve = CNT_W'($urandom_range(0, cols * rows));
                default: reserve = CNT_W'($urandom_range(0, 4));
            endcase
            write_reg(REG_RESERVE, reserve);
            if ($urandom_range(0, 4) != 0) begin
                send_item(MODE_NEW_GAME, COORD_W'($urandom), COORD_W'($urandom),
                          draw_word());
                random_items++;
            end
            phase_len = $urandom_range(8, 24);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    if (cols != 0 && rows != 0)
                        send_item(MODE_MARK_PICK, COORD_W'($urandom_range(0, cols - 1)),
                                  COORD_W'($urandom_range(0, rows - 1)), draw_word());
                    else
                        send_item(MODE_MARK_PICK, COORD_W'($urandom), COORD_W'($urandom),
                                  draw_word());
                    random_items++;
                end else if (roll < 80) begin
                    send_item(MODE_PICK, COORD_W'($urandom), COORD_W'($urandom),
                              draw_word());
                    random_items++;
                end else if (roll < 88) begin
                    send_item(MODE_MARK_PICK, COORD_W'($urandom), COORD_W'($urandom),
                              draw_word());
                    random_items++;
                end else if (roll < 94) begin
                    send_item(MODE_NONE, COORD_W'($urandom), COORD_W'($urandom),
                              draw_word());
                end else if (roll < 97) begin
                    send_item(MODE_NEW_GAME, COORD_W'($urandom), COORD_W'($urandom),
                              draw_word());
                    random_items++;
                end else begin
                    drain_results();
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: holds m_tready low for a random pause before each result beat, none in steady flow.
    initial begin : result_sink
        int unsigned hold;

        m_tready = 1'b0;
        forever begin
            hold = steady_flow ? 0 : $urandom_range(0, 9);
            repeat (hold) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Every result beat is compared with the oldest expectation.
    always @(posedge aclk) begin : check_results
        pick_t want;

        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_picks.size() == 0) begin
                $error("result beat with nothing expected: pick_x %0d pick_y %0d placed %0d",
                       m_tdata[4:0], m_tdata[9:5], m_tuser);
                error_count++;
            end else begin
                want = pending_picks.pop_front();
                if (m_tdata[4:0] !== want.x) begin
                    $error("pick_x expected %0d, got %0d", want.x, m_tdata[4:0]);
                    error_count++;
                end
                if (m_tdata[9:5] !== want.y) begin
                    $error("pick_y expected %0d, got %0d", want.y, m_tdata[9:5]);
                    error_count++;
                end
                if (m_tuser !== want.placed) begin
                    $error("placed expected %0d, got %0d", want.placed, m_tuser);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_picks.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_NONE;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_wdata = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // The clearing pass after reset holds s_tready low; the first beats
        // simply wait on the handshake.
        test_empty_count();
        test_first_game();
        test_grid_limits();
        test_shrunk_grid();
        test_reserve_edge();
        test_random_games();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d beats (%0d games, %0d random phases); checked %0d results.",
                 beats_sent, games_started, phases_run, results_checked);
        $display("Results: %0d cells placed, %0d passes, %0d cycles.",
                 placements, passes, cycle_count);
        if (error_count == 0 && pending_picks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
